FILE: rtl/mcl_pkg.sv
// Shared types, constants and month tables for the month calendar layout block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mcl_pkg;

	// Field widths.
	localparam int YEAR_W  = 16;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int WD_W    = 3;

	// Shared divider: dividend width, remainder width, quotient-by-100 width; then the days-before width.
	localparam int DIV_W   = 17;
	localparam int REM_W   = 7;
	localparam int Q100_W  = 10;
	localparam int DB_W    = 9;

	// Scaled reciprocals of the two divisors. Each gives the exact quotient for
	// every dividend the block produces (below 91180 for 100, below 349525 for 7).
	localparam int RCP_W             = 18;
	localparam int PROD_W            = DIV_W + RCP_W;
	localparam int RCP_SHIFT_CENTURY = 23;
	localparam int RCP_SHIFT_WEEK    = 20;
	localparam logic [RCP_W-1:0] RCP_CENTURY = RCP_W'(83887);
	localparam logic [RCP_W-1:0] RCP_WEEK    = RCP_W'(149797);

	localparam logic [REM_W-1:0]  DIVISOR_CENTURY = REM_W'(100);
	localparam logic [REM_W-1:0]  DIVISOR_WEEK    = REM_W'(7);
	localparam logic [YEAR_W-1:0] YEAR_ZERO_ALIAS = YEAR_W'(400);
	localparam logic [WD_W-1:0]   SATURDAY        = WD_W'(6);
	localparam logic [WD_W-1:0]   SUNDAY          = WD_W'(0);
	localparam logic [MONTH_W-1:0] JANUARY        = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] FEBRUARY       = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] DECEMBER       = MONTH_W'(12);

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CENTURY,
		ST_SUM,
		ST_WEEK,
		ST_EMIT,
		ST_ERR
	} mcl_state_t;

	// Request into the shared divider.
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [REM_W-1:0] divisor;
	} div_req_t;

	// Response from the shared divider.
	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [REM_W-1:0] rem;
	} div_rsp_t;

	// Days before the first of a month in a common year.
	function automatic logic [DB_W-1:0] days_before(input logic [MONTH_W-1:0] m);
		logic [DB_W-1:0] d;
		case (m)
			4'd1:    d = DB_W'(0);
			4'd2:    d = DB_W'(31);
			4'd3:    d = DB_W'(59);
			4'd4:    d = DB_W'(90);
			4'd5:    d = DB_W'(120);
			4'd6:    d = DB_W'(151);
			4'd7:    d = DB_W'(181);
			4'd8:    d = DB_W'(212);
			4'd9:    d = DB_W'(243);
			4'd10:   d = DB_W'(273);
			4'd11:   d = DB_W'(304);
			4'd12:   d = DB_W'(334);
			default: d = DB_W'(0);
		endcase
		return d;
	endfunction

	// Length of a month in a common year.
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] d;
		case (m)
			4'd2:                   d = DAY_W'(28);
			4'd4, 4'd6, 4'd9, 4'd11: d = DAY_W'(30);
			default:                d = DAY_W'(31);
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/mcl_div.sv
// Shared divider for the two constant divisors, 100 and 7, by reciprocal multiplication.
// Depends on mcl_pkg for widths, reciprocal constants and the request/response structs.
`timescale 1ns / 1ps
`default_nettype none

module mcl_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mcl_pkg::div_req_t   req,
	output mcl_pkg::div_rsp_t        rsp
);
	import mcl_pkg::*;

	logic              mul_q;
	logic              back_q;
	logic              done_q;
	logic [DIV_W-1:0]  dvd_q;
	logic [REM_W-1:0]  dvs_q;
	logic [DIV_W-1:0]  quot_q;
	logic [REM_W-1:0]  rem_q;

	logic [RCP_W-1:0]  rcp;
	logic [PROD_W-1:0] prod;
	logic [DIV_W-1:0]  quot;
	logic [DIV_W-1:0]  rem_full;

	// Quotient from the scaled reciprocal; any divisor other than 7 is taken as 100.
	// The remainder is the dividend less the quotient times the divisor.
	always_comb begin
		case (dvs_q)
			DIVISOR_WEEK: rcp = RCP_WEEK;
			default:      rcp = RCP_CENTURY;
		endcase
		prod = PROD_W'(dvd_q) * PROD_W'(rcp);
		case (dvs_q)
			DIVISOR_WEEK: quot = DIV_W'(prod >> RCP_SHIFT_WEEK);
			default:      quot = DIV_W'(prod >> RCP_SHIFT_CENTURY);
		endcase
		rem_full = dvd_q - quot_q * DIV_W'(dvs_q);
	end

	// Control: start moves through mul_q and back_q to done_q; quotient, then remainder with the done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q  <= 1'b0;
			back_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			mul_q  <= req.start;
			back_q <= mul_q;
			done_q <= back_q;
		end
	end

	// Datapath: operands, then quotient, then remainder.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end
		if (mul_q) begin
			quot_q <= quot;
		end
		if (back_q) begin
			rem_q <= rem_full[REM_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

FILE: rtl/month_calendar_layout_core.sv
// Top level of the month calendar layout block: sequencer, day count and output stage.
// Depends on mcl_pkg and the shared divider mcl_div.
`timescale 1ns / 1ps
`default_nettype none

// Takes a year and a month and emits one transaction per day of that month
// (28 to 31), each with its day number, weekday column (0 is Sunday), a
// Saturday row-end flag, the leap-year flag and a last flag; a month outside
// 1..12 gives one transaction with bad_month and last set. Year 0 is treated
// as year 400. Setup uses one shared reciprocal-multiply divider twice,
// first to divide the year by 100 for the leap rule and the century count,
// then to reduce the day count of the first modulo 7. Days leave at one per
// cycle while the consumer keeps out_ready high, and the next input
// transaction can be taken only after the last day has been loaded into the
// output register. A bad month skips the modulo-7 step and gives its
// transaction once the year has been divided by 100. in_ready is high only
// while the block is idle; the final day may still wait in the output
// register while the next year and month are taken.
module month_calendar_layout_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [mcl_pkg::YEAR_W-1:0]  year,
	input  wire logic [mcl_pkg::MONTH_W-1:0] month,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [mcl_pkg::DAY_W-1:0]        day_number,
	output logic [mcl_pkg::WD_W-1:0]         weekday,
	output logic                             row_end,
	output logic                             leap_year,
	output logic                             bad_month,
	output logic                             last
);
	import mcl_pkg::*;

	mcl_state_t state_q, state_d;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [YEAR_W-1:0]  year_q;
	logic [MONTH_W-1:0] month_q;
	logic               leap_q;
	logic [Q100_W-1:0]  qp_q;
	logic [DAY_W-1:0]   len_q;
	logic [DAY_W-1:0]   day_q;
	logic [WD_W-1:0]    wd_q;
	logic               out_valid_q;

	logic [YEAR_W-1:0]  year_eff;
	logic               load_out;
	logic               in_take;
	logic               month_bad;
	logic [Q100_W-1:0]  q100;
	logic               r100_zero;
	logic               leap_calc;
	logic [DIV_W-1:0]   prior;
	logic [DIV_W-1:0]   day_sum;
	logic [DAY_W-1:0]   len_calc;

	mcl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Year zero stands for year 400.
	assign year_eff = (year == '0) ? YEAR_ZERO_ALIAS : year;

	// Leap status and the century count of prior years from year / 100; month range check.
	always_comb begin
		q100      = div_rsp.quot[Q100_W-1:0];
		r100_zero = (div_rsp.rem == '0);
		leap_calc = (year_q[1:0] == 2'b00) && (!r100_zero || (q100[1:0] == 2'b00));
		month_bad = (month_q < JANUARY) || (month_q > DECEMBER);
	end

	// Day count of the first of the month, reduced later modulo 7 (365 is 1 mod 7); month length.
	always_comb begin
		prior   = DIV_W'(year_q - YEAR_W'(1));
		day_sum = prior + (prior >> 2) - DIV_W'(qp_q) + DIV_W'(qp_q >> 2)
			+ DIV_W'(days_before(month_q)) + DIV_W'(1)
			+ DIV_W'((month_q > FEBRUARY) && leap_q);
		len_calc = ((month_q == FEBRUARY) && leap_q) ? DAY_W'(29) : month_len(month_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (in_valid) state_d = ST_CENTURY;
			ST_CENTURY: if (div_rsp.done) state_d = month_bad ? ST_ERR : ST_SUM;
			ST_SUM:     state_d = ST_WEEK;
			ST_WEEK:    if (div_rsp.done) state_d = ST_EMIT;
			ST_EMIT:    if (load_out && (day_q == len_q)) state_d = ST_IDLE;
			ST_ERR:     if (load_out) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = DIV_W'(year_eff);
		div_req.divisor  = DIVISOR_CENTURY;
		load_out         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				div_req.start = in_valid;
			end
			ST_SUM: begin
				div_req.start    = 1'b1;
				div_req.dividend = day_sum;
				div_req.divisor  = DIVISOR_WEEK;
			end
			ST_EMIT, ST_ERR: load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign in_take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers of the current month.
	always_ff @(posedge clk) begin
		if (in_take) begin
			year_q  <= year_eff;
			month_q <= month;
		end
		if ((state_q == ST_CENTURY) && div_rsp.done) begin
			leap_q <= leap_calc;
			qp_q   <= r100_zero ? (q100 - Q100_W'(1)) : q100;
		end
		if (state_q == ST_SUM) begin
			len_q <= len_calc;
			day_q <= DAY_W'(1);
		end
		if ((state_q == ST_WEEK) && div_rsp.done) begin
			wd_q <= div_rsp.rem[WD_W-1:0];
		end
		if ((state_q == ST_EMIT) && load_out) begin
			day_q <= day_q + DAY_W'(1);
			wd_q  <= (wd_q == SATURDAY) ? SUNDAY : wd_q + WD_W'(1);
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_out) begin
			leap_year <= leap_q;
			if (state_q == ST_ERR) begin
				day_number <= '0;
				weekday    <= SUNDAY;
				row_end    <= 1'b0;
				bad_month  <= 1'b1;
				last       <= 1'b1;
			end else begin
				day_number <= day_q;
				weekday    <= wd_q;
				row_end    <= (wd_q == SATURDAY);
				bad_month  <= 1'b0;
				last       <= (day_q == len_q);
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/mcl_checker.sv
// Port-level checks for the month calendar layout block, bound to the top level.
// Depends on mcl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module mcl_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic                        in_ready,
	input  wire logic                        out_valid,
	input  wire logic                        out_ready,
	input  wire logic [mcl_pkg::DAY_W-1:0]   day_number,
	input  wire logic [mcl_pkg::WD_W-1:0]    weekday,
	input  wire logic                        row_end,
	input  wire logic                        bad_month,
	input  wire logic                        last
);
	import mcl_pkg::*;

	// A stalled result transaction stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// After an input transaction the block is busy with setup.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken during setup");

	// The row-end flag marks exactly the Saturday column of a day result.
	a_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_month |-> (row_end == (weekday == SATURDAY)))
		else $error("row_end does not match weekday");

	// An error result is a single closing transaction with day zero.
	a_bad_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_month |-> last && (day_number == '0) && !row_end)
		else $error("malformed error result");

endmodule

bind month_calendar_layout_core mcl_checker u_mcl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.day_number (day_number),
	.weekday    (weekday),
	.row_end    (row_end),
	.bad_month  (bad_month),
	.last       (last)
);

`default_nettype wire
